/* rtl/udpq_pkg.sv */
// ----------------------------------------------------------------------------
// udpq_pkg
// Shared types and constants for the UDP port demultiplexer and its queues.
// ----------------------------------------------------------------------------
package udpq_pkg;

    localparam int PORT_SLOTS_DEF  = 128;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Request codes
    typedef enum logic [1:0] {
        FN_BIND    = 2'd0,
        FN_DELIVER = 2'd1,
        FN_RECEIVE = 2'd2,
        FN_NONE    = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_NOT_UDP    = 3'd2,
        ST_NOT_BOUND  = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_MISS,
        S_QRD,
        S_QCHK,
        S_ERD,
        S_DONE
    } state_t;

endpackage

/* rtl/udpq_ram.sv */
// ----------------------------------------------------------------------------
// udpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module udpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/udp_port_demux_queue_core.sv */
// ----------------------------------------------------------------------------
// udp_port_demux_queue_core
// UDP destination port table with one descriptor FIFO per bound port.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per beat. s_tuser carries the function
//   (bind, deliver, receive); code 3 is swallowed with no result.
//   Master channel m_*: one result per bind, deliver or receive request.
//   Sequence: the bound port table sits in RAM and is searched one slot
//   at a time, with a read step (S_SRD) and a compare step (S_SCMP) per
//   slot. A match goes on to the queue state and descriptor RAM steps
//   (S_QRD, S_QCHK, S_ERD) as the request needs, a miss to S_MISS, and
//   S_DONE then loads the output register. Non-UDP delivers skip the
//   search. One request is in flight at a time; s_tready is high only
//   while the sequencer is idle.
//   The output register holds a finished result while m_tready is low; a
//   new request is still taken, and its result waits in the sequencer.
//   Reset empties the port table; queue state for a slot is cleared when
//   the slot is bound, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module udp_port_demux_queue_core
    import udpq_pkg::*;
#(
    parameter int PORT_SLOTS  = PORT_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dest_port[15:0], ip_protocol[23:16], source_ip[55:24], source_port[71:56],
    // payload_length[87:72], buffer_handle[119:88], max_length[135:120]
    input  logic [135:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_source_ip[31:0], out_source_port[47:32], copy_length[63:48],
    // out_buffer_handle[95:64]
    output logic [95:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    localparam int SLOT_W    = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int CNT_W     = $clog2(PORT_SLOTS + 1);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W      = 2 * PTR_W + QCNT_W;
    localparam int ENT_DEPTH = PORT_SLOTS * QUEUE_DEPTH;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);

    state_t state_reg, state_next;

    // Latched request
    func_t       func_reg;
    logic [15:0] port_reg, plen_reg, sport_reg, maxlen_reg;
    logic [31:0] sip_reg, handle_reg;

    logic [SLOT_W-1:0] idx_reg, slot_reg;
    logic [CNT_W-1:0]  count_reg;

    // Pending result
    status_t     res_status_reg;
    logic [31:0] res_sip_reg, res_handle_reg;
    logic [15:0] res_sport_reg, res_len_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    // RAM ports
    logic              tb_we;
    logic [SLOT_W-1:0] tb_waddr, tb_raddr;
    logic [15:0]       tb_rdata;
    logic              qs_we;
    logic [SLOT_W-1:0] qs_waddr, qs_raddr;
    logic [QS_W-1:0]   qs_wdata, qs_rdata;
    logic              en_we;
    logic [ENT_AW-1:0] en_waddr, en_raddr;
    logic [95:0]       en_wdata, en_rdata;

    logic              s_acc, out_free, match, last, has_room, q_full, q_empty;
    logic [PTR_W-1:0]  q_head, q_tail, head_inc, tail_inc;
    logic [QCNT_W-1:0] q_cnt;
    logic [15:0]       e_len;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign match    = (tb_rdata == port_reg);
    assign last     = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign has_room = count_reg < CNT_W'(PORT_SLOTS);

    // Queue state fields
    assign {q_head, q_tail, q_cnt} = qs_rdata;
    assign q_full   = q_cnt == QCNT_W'(QUEUE_DEPTH);
    assign q_empty  = q_cnt == '0;
    assign head_inc = (q_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + PTR_W'(1);
    assign tail_inc = (q_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail + PTR_W'(1);
    assign e_len    = en_rdata[63:48];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && func_t'(s_tuser) != FN_NONE)
                begin
                    if (func_t'(s_tuser) == FN_DELIVER && s_tdata[23:16] != PROTO_UDP)
                        state_next = S_DONE;
                    else if (count_reg == '0)
                        state_next = S_MISS;
                    else
                        state_next = S_SRD;
                end
            end
            S_SRD:  state_next = S_SCMP;
            S_SCMP:
            begin
                priority if (match)
                    state_next = (func_reg == FN_BIND) ? S_DONE : S_QRD;
                else if (last)
                    state_next = S_MISS;
                else
                    state_next = S_SRD;
            end
            S_MISS: state_next = S_DONE;
            S_QRD:  state_next = S_QCHK;
            S_QCHK: state_next = (func_reg == FN_RECEIVE && !q_empty) ? S_ERD : S_DONE;
            S_ERD:  state_next = S_DONE;
            S_DONE: state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // RAM control and handshake
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        tb_we    = 1'b0;
        tb_waddr = SLOT_W'(count_reg);
        tb_raddr = idx_reg;
        qs_we    = 1'b0;
        qs_waddr = slot_reg;
        qs_wdata = '0;
        qs_raddr = slot_reg;
        en_we    = 1'b0;
        en_waddr = ENT_AW'(ENT_AW'(slot_reg) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(q_tail));
        en_wdata = {handle_reg, plen_reg, sport_reg, sip_reg};
        en_raddr = ENT_AW'(ENT_AW'(slot_reg) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(q_head));
        unique case (state_reg)
            S_MISS:
            begin
                // new binding: fresh slot with an empty queue
                if (func_reg == FN_BIND && has_room)
                begin
                    tb_we    = 1'b1;
                    qs_we    = 1'b1;
                    qs_waddr = SLOT_W'(count_reg);
                end
            end
            S_QCHK:
            begin
                if (func_reg == FN_DELIVER && !q_full)
                begin
                    en_we    = 1'b1;
                    qs_we    = 1'b1;
                    qs_wdata = {q_head, tail_inc, q_cnt + QCNT_W'(1)};
                end
                else if (func_reg == FN_RECEIVE && !q_empty)
                begin
                    qs_we    = 1'b1;
                    qs_wdata = {head_inc, q_tail, q_cnt - QCNT_W'(1)};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tb_we)
                count_reg <= count_reg + CNT_W'(1);
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    func_reg       <= func_t'(s_tuser);
                    port_reg       <= s_tdata[15:0];
                    sip_reg        <= s_tdata[55:24];
                    sport_reg      <= s_tdata[71:56];
                    plen_reg       <= s_tdata[87:72];
                    handle_reg     <= s_tdata[119:88];
                    maxlen_reg     <= s_tdata[135:120];
                    idx_reg        <= '0;
                    res_status_reg <= ST_OK;
                    res_sip_reg    <= '0;
                    res_sport_reg  <= '0;
                    res_len_reg    <= '0;
                    res_handle_reg <= '0;
                    if (func_t'(s_tuser) == FN_DELIVER && s_tdata[23:16] != PROTO_UDP)
                    begin
                        res_status_reg <= ST_NOT_UDP;
                        res_handle_reg <= s_tdata[119:88];
                    end
                end
            end
            S_SCMP:
            begin
                slot_reg <= idx_reg;
                if (!match && !last)
                    idx_reg <= idx_reg + SLOT_W'(1);
            end
            S_MISS:
            begin
                if (func_reg == FN_BIND)
                    res_status_reg <= has_room ? ST_OK : ST_TABLE_FULL;
                else
                    res_status_reg <= ST_NOT_BOUND;
                if (func_reg == FN_DELIVER)
                    res_handle_reg <= handle_reg;
            end
            S_QCHK:
            begin
                if (func_reg == FN_DELIVER && q_full)
                begin
                    res_status_reg <= ST_QUEUE_FULL;
                    res_handle_reg <= handle_reg;
                end
                else if (func_reg == FN_RECEIVE && q_empty)
                    res_status_reg <= ST_EMPTY;
            end
            S_ERD:
            begin
                res_sip_reg    <= en_rdata[31:0];
                res_sport_reg  <= en_rdata[47:32];
                res_len_reg    <= (e_len > maxlen_reg) ? maxlen_reg : e_len;
                res_handle_reg <= en_rdata[95:64];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {res_handle_reg, res_len_reg, res_sport_reg, res_sip_reg};
                    m_tuser_reg <= res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Bound port table
    udpq_ram #(.WIDTH(16), .DEPTH(PORT_SLOTS), .AW(SLOT_W)) u_table (
        .clk   (clk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (port_reg),
        .raddr (tb_raddr),
        .rdata (tb_rdata)
    );

    // Per-slot head, tail and count
    udpq_ram #(.WIDTH(QS_W), .DEPTH(PORT_SLOTS), .AW(SLOT_W)) u_qstate (
        .clk   (clk),
        .we    (qs_we),
        .waddr (qs_waddr),
        .wdata (qs_wdata),
        .raddr (qs_raddr),
        .rdata (qs_rdata)
    );

    // Descriptor storage
    udpq_ram #(.WIDTH(96), .DEPTH(ENT_DEPTH), .AW(ENT_AW)) u_entries (
        .clk   (clk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .raddr (en_raddr),
        .rdata (en_rdata)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the UDP port demultiplexer: binds, delivers and receives are driven
// on the request stream, a behavioural copy of the port table and per-port
// descriptor FIFOs predicts each result, and a monitor compares every result
// field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import udpq_pkg::*;
();

    localparam int NUM_SLOTS   = PORT_SLOTS_DEF;
    localparam int FIFO_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        status_t     status;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] copy_len;
        logic [31:0] handle;
    } udp_result_t;

    typedef struct {
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] length;
        logic [31:0] handle;
    } rx_desc_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;

    // Predictor state
    logic [15:0]  table_ports[NUM_SLOTS];
    int           num_bound;
    rx_desc_t     port_fifo[NUM_SLOTS][$];

    udp_result_t  pending_results[$];
    int           errors;
    int           cycles;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;
    logic [15:0]  port_pool[$];

    udp_port_demux_queue_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Returns the table slot of a port, or -1 when unbound
    function automatic int slot_of(logic [15:0] port);
        for (int i = 0; i < num_bound; i++)
            if (table_ports[i] == port)
                return i;
        return -1;
    endfunction

    // Works out the result of one request and updates the predicted state
    function automatic void predict_request(func_t fn, logic [15:0] port,
                                            logic [7:0] proto, logic [31:0] sip,
                                            logic [15:0] sport, logic [15:0] plen,
                                            logic [31:0] hdl, logic [15:0] maxlen);
        udp_result_t r;
        rx_desc_t    d;
        int          slot;
        if (fn == FN_NONE)
            return;
        r = '0;
        r.status = ST_OK;
        slot = slot_of(port);
        case (fn)
            FN_BIND:
            begin
                if (slot < 0)
                begin
                    if (num_bound < NUM_SLOTS)
                    begin
                        table_ports[num_bound] = port;
                        port_fifo[num_bound].delete();
                        num_bound++;
                    end
                    else
                        r.status = ST_TABLE_FULL;
                end
            end
            FN_DELIVER:
            begin
                if (proto != PROTO_UDP)
                begin
                    r.status = ST_NOT_UDP;
                    r.handle = hdl;
                end
                else if (slot < 0)
                begin
                    r.status = ST_NOT_BOUND;
                    r.handle = hdl;
                end
                else if (port_fifo[slot].size() >= FIFO_DEPTH)
                begin
                    r.status = ST_QUEUE_FULL;
                    r.handle = hdl;
                end
                else
                begin
                    d.src_ip = sip;
                    d.src_port = sport;
                    d.length = plen;
                    d.handle = hdl;
                    port_fifo[slot].push_back(d);
                end
            end
            default:
            begin
                if (slot < 0)
                    r.status = ST_NOT_BOUND;
                else if (port_fifo[slot].size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    d = port_fifo[slot].pop_front();
                    r.src_ip = d.src_ip;
                    r.src_port = d.src_port;
                    r.copy_len = (d.length > maxlen) ? maxlen : d.length;
                    r.handle = d.handle;
                end
            end
        endcase
        pending_results.push_back(r);
    endfunction

    // Sends one request and records its expected result; tvalid stays up
    // after the handshake until the next request or a pause drops it
    task automatic send_request(func_t fn, logic [15:0] port, logic [7:0] proto,
                                logic [31:0] sip, logic [15:0] sport,
                                logic [15:0] plen, logic [31:0] hdl,
                                logic [15:0] maxlen);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {maxlen, hdl, plen, sport, sip, proto, port};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(fn, port, proto, sip, sport, plen, hdl, maxlen);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Picks a port: mostly from the bound or recently used pool
    function automatic logic [15:0] pick_port();
        if (port_pool.size() != 0 && $urandom_range(9) < 8)
            return port_pool[$urandom_range(port_pool.size() - 1)];
        return 16'($urandom);
    endfunction

    task automatic random_request(int deliver_weight);
        int          sel;
        func_t       fn;
        logic [15:0] port;
        logic [7:0]  proto;
        sel = $urandom_range(99);
        if (sel < 8)
            fn = FN_BIND;
        else if (sel < 8 + deliver_weight)
            fn = FN_DELIVER;
        else if (sel < 98)
            fn = FN_RECEIVE;
        else
            fn = FN_NONE;
        port  = pick_port();
        proto = ($urandom_range(9) == 0) ? 8'($urandom) : PROTO_UDP;
        if (fn == FN_BIND && port_pool.size() < 24)
            port_pool.push_back(port);
        send_request(fn, port, proto, $urandom, 16'($urandom),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)),
                     $urandom, ($urandom_range(1) == 0) ? 16'($urandom) : 16'hFFFF);
    endtask

    // Extreme fields, each status code but table full, and the unused function
    task automatic test_directed();
        send_request(FN_RECEIVE, 16'h0000, 8'h00, '0, '0, '0, '0, 16'hFFFF);
        send_request(FN_DELIVER, 16'h0000, 8'hFF, '1, '1, '1, '1, '1);
        send_request(FN_DELIVER, 16'hFFFF, PROTO_UDP, '1, '1, '1, '1, '0);
        send_request(FN_BIND, 16'h0000, '0, '0, '0, '0, '0, '0);
        send_request(FN_BIND, 16'hFFFF, '1, '1, '1, '1, '1, '1);
        send_request(FN_BIND, 16'h0000, '0, '0, '0, '0, '0, '0);
        send_request(FN_NONE, 16'hFFFF, PROTO_UDP, '1, '1, '1, '1, '1);
        send_request(FN_RECEIVE, 16'hFFFF, '0, '0, '0, '0, '0, '1);
        send_request(FN_DELIVER, 16'hFFFF, PROTO_UDP, '1, '1, '1, '1, '1);
        send_request(FN_DELIVER, 16'hFFFF, PROTO_UDP, '0, '0, '0, '0, '0);
        send_request(FN_DELIVER, 16'h0000, PROTO_UDP, 32'hA5A5_5A5A, 16'h5A5A,
                     16'd1500, 32'h1234_5678, '0);
        send_request(FN_RECEIVE, 16'hFFFF, '0, '0, '0, '0, '0, 16'd100);
        send_request(FN_RECEIVE, 16'hFFFF, '0, '0, '0, '0, '0, '1);
        send_request(FN_RECEIVE, 16'hFFFF, '0, '0, '0, '0, '0, '1);
        send_request(FN_RECEIVE, 16'h0000, '0, '0, '0, '0, '0, 16'd1500);
        // Fill one queue past its depth
        for (int i = 0; i < FIFO_DEPTH + 2; i++)
            send_request(FN_DELIVER, 16'h0000, PROTO_UDP, $urandom, 16'($urandom),
                         16'($urandom), $urandom, '0);
        port_pool.push_back(16'h0000);
        port_pool.push_back(16'hFFFF);
    endtask

    task automatic test_random(int n, int deliver_weight);
        for (int i = 0; i < n; i++)
            random_request(deliver_weight);
    endtask

    // Receiver holds off while requests keep coming, then sender waits
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            random_request(45);
        wait_drained();
    endtask

    // Binds until the table is full, then rebinds and overflows it
    task automatic test_table_full();
        for (int i = num_bound; i < NUM_SLOTS; i++)
            send_request(FN_BIND, 16'(16'h8000 + i), '0, '0, '0, '0, '0, '0);
        send_request(FN_BIND, 16'h7777, '0, '0, '0, '0, '0, '0);
        send_request(FN_BIND, 16'h8000 + 16'(NUM_SLOTS - 1), '0, '0, '0, '0, '0, '0);
        send_request(FN_BIND, 16'h0000, '0, '0, '0, '0, '0, '0);
        port_pool.push_back(16'h8000 + 16'(NUM_SLOTS - 1));
    endtask

    // Receiver ready, with a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        udp_result_t exp_r;
        udp_result_t got_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r = {status_t'(m_tuser), m_tdata[31:0], m_tdata[47:32],
                     m_tdata[63:48], m_tdata[95:64]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%h", $time, m_tuser,
                         m_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got_r.status !== exp_r.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             got_r.status);
                    errors++;
                end
                if (got_r.src_ip !== exp_r.src_ip)
                begin
                    $display("%0t: source_ip exp %h got %h", $time, exp_r.src_ip,
                             got_r.src_ip);
                    errors++;
                end
                if (got_r.src_port !== exp_r.src_port)
                begin
                    $display("%0t: source_port exp %h got %h", $time, exp_r.src_port,
                             got_r.src_port);
                    errors++;
                end
                if (got_r.copy_len !== exp_r.copy_len)
                begin
                    $display("%0t: copy_length exp %h got %h", $time, exp_r.copy_len,
                             got_r.copy_len);
                    errors++;
                end
                if (got_r.handle !== exp_r.handle)
                begin
                    $display("%0t: buffer_handle exp %h got %h", $time, exp_r.handle,
                             got_r.handle);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("[udp_port_demux_queue_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FN_NONE;
        errors = 0;
        cycles = 0;
        num_bound = 0;
        hold_cycles = 0;
        send_idle_pct = 16;
        recv_idle_pct = 68;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(550, 45);
        test_backpressure();
        send_idle_pct = 68;
        recv_idle_pct = 16;
        test_random(500, 45);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200, 45);
        test_table_full();
        test_random(300, 45);

        wait_drained();
        if (errors == 0)
            $display("[udp_port_demux_queue_core] OK");
        else
            $display("[udp_port_demux_queue_core] ERROR");
        $finish;
    end
endmodule
